@@ design/adaptive_width_packed_int_array_defines.svh @@
// Assertion macros used by the checker module.
`ifndef ADAPTIVE_WIDTH_PACKED_INT_ARRAY_DEFINES_SVH
`define ADAPTIVE_WIDTH_PACKED_INT_ARRAY_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AWPIA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AWPIA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/awpia_pkg.sv @@
package awpia_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 64;

	localparam logic [2:0] OP_GET    = 3'd0;
	localparam logic [2:0] OP_SET    = 3'd1;
	localparam logic [2:0] OP_INSERT = 3'd2;
	localparam logic [2:0] OP_DELETE = 3'd3;
	localparam logic [2:0] OP_FIND   = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [2:0]              operation;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] operand_value;
		logic [POS_W-1:0]        range_end;
		logic                    end_is_length;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [9:0]              match_index;
		logic                    match_found;
		logic [1:0]              status;
		logic [6:0]              entry_width;
		logic [POS_W-1:0]        entry_count;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_INS_TEST, S_INS_WR, S_DEL_TEST, S_DEL_WR,
		S_FIND_RD, S_FIND_CMP, S_PUT, S_FINISH
	} state_t;

	typedef enum logic [1:0] {RA_POS, RA_IDX, RA_IDX_DN, RA_IDX_UP} raddr_t;

	typedef struct packed {
		logic   load;
		logic   chk;
		logic   rd_en;
		raddr_t rd_sel;
		logic   wr_shift;
		logic   wr_val;
		logic   idx_ld_len;
		logic   idx_ld_pos;
		logic   idx_inc;
		logic   idx_dec;
		logic   commit;
		logic   hit;
		logic   finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       bad;
		logic       full;
		logic       scan;
		logic       idx_above_pos;
		logic       more_del;
		logic       more_find;
		logic       match;
		logic       out_free;
	} stat_t;

	// Width code a value needs: codes 0..7 stand for widths 0,1,2,4,8,16,32,64.
	function automatic logic [2:0] need_code(input logic [VAL_W-1:0] v);
		logic [VAL_W-1:0] f;
		logic [2:0] c;
		f = v[VAL_W-1] ? ~v : v;
		if (v[VAL_W-1:4] == '0) begin
			case (v[3:0])
				4'd0: c = 3'd0;
				4'd1: c = 3'd1;
				4'd2, 4'd3: c = 3'd2;
				default: c = 3'd3;
			endcase
		end else if (f[VAL_W-1:31] != '0) begin
			c = 3'd7;
		end else if (f[30:15] != '0) begin
			c = 3'd6;
		end else if (f[14:7] != '0) begin
			c = 3'd5;
		end else begin
			c = 3'd4;
		end
		return c;
	endfunction

	function automatic logic [6:0] code_width(input logic [2:0] c);
		return (c == 3'd0) ? 7'd0 : (7'd1 << (c - 3'd1));
	endfunction

endpackage

@@ design/awpia_ctrl.sv @@
module awpia_ctrl
	import awpia_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = RA_POS;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.chk = 1'b1;
				state_d = S_FINISH;
				case (stat.op)
					OP_GET: begin
						if (!stat.bad) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = RA_POS;
						end
					end
					OP_SET: begin
						if (!stat.bad && !stat.full) begin
							state_d = S_PUT;
						end
					end
					OP_INSERT: begin
						if (!stat.bad && !stat.full) begin
							cmd.idx_ld_len = 1'b1;
							state_d = S_INS_TEST;
						end
					end
					OP_DELETE: begin
						if (!stat.bad) begin
							cmd.idx_ld_pos = 1'b1;
							state_d = S_DEL_TEST;
						end
					end
					OP_FIND: begin
						if (stat.scan) begin
							cmd.idx_ld_pos = 1'b1;
							state_d = S_FIND_RD;
						end
					end
					OP_CLEAR: cmd.commit = 1'b1;
					default: ;
				endcase
			end
			// Entries above the insert point move up one place, top first.
			S_INS_TEST: begin
				if (stat.idx_above_pos) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_IDX_DN;
					state_d = S_INS_WR;
				end else begin
					state_d = S_PUT;
				end
			end
			S_INS_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d = S_INS_TEST;
			end
			S_DEL_TEST: begin
				if (stat.more_del) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_IDX_UP;
					state_d = S_DEL_WR;
				end else begin
					cmd.commit = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_DEL_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d = S_DEL_TEST;
			end
			S_FIND_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RA_IDX;
				state_d = S_FIND_CMP;
			end
			S_FIND_CMP: begin
				if (stat.match) begin
					cmd.hit = 1'b1;
					state_d = S_FINISH;
				end else if (stat.more_find) begin
					cmd.idx_inc = 1'b1;
					state_d = S_FIND_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_PUT: begin
				cmd.wr_val = 1'b1;
				cmd.commit = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ design/awpia_dpath.sv @@
module awpia_dpath
	import awpia_pkg::*;
#(
	parameter int STORE_BYTES = 8192,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output stat_t     stat,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam logic [31:0] CNT_LIMIT = 32'(MAX_ENTRIES);
	localparam logic [31:0] BYTE_LIMIT = 32'(STORE_BYTES);

	// One word per entry; every stored value fits the width in use, so a
	// widening needs no repack pass.
	logic [VAL_W-1:0] mem [MAX_ENTRIES];
	logic [VAL_W-1:0] rdata_q;

	in_item_t req_q;
	logic [POS_W-1:0] len_q, idx_q;
	logic [2:0] wcode_q;
	logic [1:0] st_q;
	logic found_q;
	logic [9:0] midx_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [2:0] ncode;
	logic [POS_W:0] cnt;
	logic [31:0] bits_v, bytes_v;
	logic fits;
	logic [POS_W-1:0] end_v;
	logic find_live, find_bad;
	logic [POS_W-1:0] raddr;

	always_comb begin
		ncode = (need_code(req_q.operand_value) > wcode_q) ?
			need_code(req_q.operand_value) : wcode_q;
		cnt = (req_q.operation == OP_INSERT) ? ({1'b0, len_q} + 1'b1) : {1'b0, len_q};
		bits_v = (ncode == 3'd0) ? 32'd0 : (32'(cnt) << (ncode - 3'd1));
		bytes_v = (bits_v + 32'd7) >> 3;
		fits = (32'(cnt) <= CNT_LIMIT) && (bytes_v <= BYTE_LIMIT);

		end_v = req_q.end_is_length ? len_q : req_q.range_end;
		find_live = (len_q != '0) && (req_q.position != end_v);
		find_bad = find_live && ((req_q.position >= end_v) || (end_v > len_q));

		stat.op = req_q.operation;
		case (req_q.operation)
			OP_GET, OP_SET, OP_DELETE: stat.bad = req_q.position >= len_q;
			OP_INSERT: stat.bad = req_q.position > len_q;
			OP_FIND: stat.bad = find_bad;
			default: stat.bad = 1'b0;
		endcase
		stat.full = !fits;
		stat.scan = find_live && !find_bad && (need_code(req_q.operand_value) <= wcode_q);
		stat.idx_above_pos = idx_q > req_q.position;
		stat.more_del = ({1'b0, idx_q} + 1'b1) < {1'b0, len_q};
		stat.more_find = ({1'b0, idx_q} + 1'b1) < {1'b0, end_v};
		stat.match = rdata_q == req_q.operand_value;
		stat.out_free = !out_valid_q || out_ready;

		case (cmd.rd_sel)
			RA_IDX: raddr = idx_q;
			RA_IDX_DN: raddr = idx_q - 1'b1;
			RA_IDX_UP: raddr = idx_q + 1'b1;
			default: raddr = req_q.position;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_q <= mem[AW'(raddr)];
		end
		if (cmd.wr_shift) begin
			mem[AW'(idx_q)] <= rdata_q;
		end else if (cmd.wr_val) begin
			mem[AW'(req_q.position)] <= req_q.operand_value;
		end
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.idx_ld_len) begin
			idx_q <= len_q;
		end else if (cmd.idx_ld_pos) begin
			idx_q <= req_q.position;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.chk) begin
			if (stat.bad) begin
				st_q <= ST_BAD_INDEX;
			end else if ((req_q.operation == OP_SET || req_q.operation == OP_INSERT)
					&& !fits) begin
				st_q <= ST_FULL;
			end else begin
				st_q <= ST_OK;
			end
			found_q <= 1'b0;
			midx_q <= '0;
		end else if (cmd.hit) begin
			found_q <= 1'b1;
			midx_q <= 10'(idx_q);
		end
		if (cmd.finish) begin
			out_q.read_value <= (req_q.operation == OP_GET && st_q == ST_OK) ?
				rdata_q : '0;
			out_q.match_index <= midx_q;
			out_q.match_found <= found_q;
			out_q.status <= st_q;
			out_q.entry_width <= code_width(wcode_q);
			out_q.entry_count <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			wcode_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				case (req_q.operation)
					OP_SET: wcode_q <= ncode;
					OP_INSERT: begin
						wcode_q <= ncode;
						len_q <= len_q + 1'b1;
					end
					OP_DELETE: len_q <= len_q - 1'b1;
					OP_CLEAR: begin
						len_q <= '0;
						wcode_q <= 3'd0;
					end
					default: ;
				endcase
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ design/adaptive_width_packed_int_array.sv @@
// Get, clear and rejected items go from the check state straight to finish; set goes
// through the put state, delete of the last entry through the delete test, and insert
// at the end through the insert test and the put state. Each entry moved adds a read
// and a write state; find adds a read and a compare state per entry scanned. One item
// at a time, the next taken once the result is passed on; moves read, then write memory.
// Reset: length and width go to zero; entry memory contents are not cleared.
module adaptive_width_packed_int_array
	import awpia_pkg::*;
#(
	parameter int STORE_BYTES = 8192,
	parameter int MAX_ENTRIES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	cmd_t  cmd;
	stat_t stat;

	awpia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	awpia_dpath #(
		.STORE_BYTES (STORE_BYTES),
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ design/awpia_checker.sv @@
`include "adaptive_width_packed_int_array_defines.svh"

module awpia_checker
	import awpia_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	`AWPIA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")
	`AWPIA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a second item while one is in work")
	`AWPIA_ASSERT_IMP(a_status_code, out_valid, out_data.status != 2'd3, "undefined status code")
	`AWPIA_ASSERT_IMP(a_width_pow2, out_valid, $onehot0(out_data.entry_width), "entry width not a power of two")
	`AWPIA_ASSERT_IMP(a_found_clean, out_valid && out_data.match_found, out_data.status == ST_OK && out_data.read_value == '0, "match reported with error or read data")

endmodule

bind adaptive_width_packed_int_array awpia_checker u_awpia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ sim/adaptive_width_packed_int_array_tb.sv @@
module adaptive_width_packed_int_array_tb;
	import awpia_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 1024;
	localparam int STORE_SZ = 8192;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 550;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t result;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	// Predictor state: entries are kept as plain values, which is exact since each
	// stored value always fits the width in use.
	logic signed [63:0] entries[$];
	int                 cur_width;
	out_item_t          pending_results[$];
	dir_row_t           dir_rows[$];
	int                 fail_count;
	int                 items_sent;
	int                 results_checked;
	int                 longest_list;
	int                 idle_cycles;
	bit                 quiet;

	adaptive_width_packed_int_array dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #1 clk = ~clk;

	function automatic int width_needed(logic [63:0] v);
		logic [63:0] f;
		if (v < 64'd16) begin
			case (v[3:0])
				4'd0: return 0;
				4'd1: return 1;
				4'd2, 4'd3: return 2;
				default: return 4;
			endcase
		end
		f = v[63] ? ~v : v;
		if (f[63:31] != '0) return 64;
		if (f[30:15] != '0) return 32;
		if (f[14:7] != '0) return 16;
		return 8;
	endfunction

	function automatic bit store_fits(int count, int w);
		if (count > MAX_LEN) return 0;
		return ((count * w + 7) >> 3) <= STORE_SZ;
	endfunction

	function automatic out_item_t make_result(logic signed [63:0] rd, int idx, bit found,
			logic [1:0] st, int w, int cnt);
		out_item_t r;
		r.read_value = rd;
		r.match_index = idx[9:0];
		r.match_found = found;
		r.status = st;
		r.entry_width = w[6:0];
		r.entry_count = cnt[10:0];
		return r;
	endfunction

	function automatic in_item_t make_item(logic [2:0] op, int pos, logic signed [63:0] v,
			int rend, bit eol);
		in_item_t it;
		it.operation = op;
		it.position = pos[10:0];
		it.operand_value = v;
		it.range_end = rend[10:0];
		it.end_is_length = eol;
		return it;
	endfunction

	function automatic out_item_t array_step(in_item_t it);
		int len, pos, nw, stop;
		logic signed [63:0] rd;
		int idx;
		bit found;
		logic [1:0] st;
		len = entries.size();
		pos = it.position;
		rd = '0;
		idx = 0;
		found = 0;
		st = ST_OK;
		nw = width_needed(it.operand_value);
		if (nw < cur_width) nw = cur_width;
		case (it.operation)
			OP_GET: begin
				if (pos >= len) st = ST_BAD_INDEX;
				else rd = entries[pos];
			end
			OP_SET: begin
				if (pos >= len) st = ST_BAD_INDEX;
				else if (!store_fits(len, nw)) st = ST_FULL;
				else begin
					cur_width = nw;
					entries[pos] = it.operand_value;
				end
			end
			OP_INSERT: begin
				if (pos > len) st = ST_BAD_INDEX;
				else if (!store_fits(len + 1, nw)) st = ST_FULL;
				else begin
					cur_width = nw;
					entries.insert(pos, it.operand_value);
				end
			end
			OP_DELETE: begin
				if (pos >= len) st = ST_BAD_INDEX;
				else entries.delete(pos);
			end
			OP_FIND: begin
				stop = it.end_is_length ? len : int'(it.range_end);
				if (len != 0 && pos != stop) begin
					if (pos >= stop || stop > len) st = ST_BAD_INDEX;
					else if (width_needed(it.operand_value) <= cur_width) begin
						for (int i = pos; i < stop; i++) begin
							if (entries[i] == it.operand_value) begin
								found = 1;
								idx = i;
								break;
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				entries.delete();
				cur_width = 0;
			end
			default: ;
		endcase
		if (entries.size() > longest_list) longest_list = entries.size();
		return make_result(rd, idx, found, st, cur_width, entries.size());
	endfunction

	// Drives one item; called and returning at a falling edge.
	task automatic send_item(in_item_t it, bit typed, out_item_t typed_result);
		int gap;
		out_item_t r;
		gap = quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		r = array_step(it);
		pending_results.push_back(typed ? typed_result : r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_checked(in_item_t it);
		send_item(it, 1'b0, '0);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	function automatic logic signed [63:0] random_value();
		logic signed [63:0] v;
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 15);
			1: v = {{56{1'b0}}, 8'($urandom)} - 64'sd128;
			2: v = $signed({{48{1'b0}}, 16'($urandom)}) - 64'sd32768;
			3: v = $signed({{32{1'b0}}, 32'($urandom)}) - 64'sh8000_0000;
			4: v = {$urandom, $urandom};
			5: v = (entries.size() != 0) ? entries[$urandom_range(0, entries.size() - 1)]
				: 64'sd0;
			6: begin
				case ($urandom_range(0, 5))
					0: v = INT64_MIN;
					1: v = INT64_MAX;
					2: v = 64'sd127;
					3: v = -64'sd129;
					4: v = 64'sd32767;
					default: v = -64'sd2147483649;
				endcase
			end
			default: v = -$signed(64'($urandom_range(1, 16)));
		endcase
		return v;
	endfunction

	function automatic in_item_t random_item();
		int len, r, pos;
		logic [2:0] op;
		len = entries.size();
		r = $urandom_range(0, 99);
		if (len > 48 && r < 30) op = OP_DELETE;
		else if (r < 32) op = OP_INSERT;
		else if (r < 46) op = OP_SET;
		else if (r < 64) op = OP_GET;
		else if (r < 78) op = OP_DELETE;
		else if (r < 96) op = OP_FIND;
		else if (r < 98) op = OP_CLEAR;
		else op = r[0] ? OP_SPARE6 : OP_SPARE7;
		case ($urandom_range(0, 9))
			0: pos = $urandom_range(0, 2047);
			1: pos = len + 1;
			default: pos = $urandom_range(0, len);
		endcase
		return make_item(op, pos, random_value(),
			$urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, len),
			$urandom_range(0, 1));
	endfunction

	task automatic build_directed;
		dir_row_t d;
		logic signed [63:0] vals[$];
		vals = '{64'sd0, 64'sd1, 64'sd15, -64'sd1, 64'sd127, -64'sd128, 64'sd128,
			-64'sd32769, INT64_MAX, INT64_MIN};
		// Empty list: bad index on get and insert, empty find.
		d.typed = 1;
		d.item = make_item(OP_GET, 0, 64'sd0, 0, 0);
		d.result = make_result(0, 0, 0, ST_BAD_INDEX, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_INSERT, 1, 64'sd5, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_FIND, 0, 64'sd0, 0, 1);
		d.result = make_result(0, 0, 0, ST_OK, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_INSERT, 0, 64'sd0, 0, 0);
		d.result = make_result(0, 0, 0, ST_OK, 0, 1);
		dir_rows.push_back(d);
		// At width 0 a find for zero matches at the range start.
		d.item = make_item(OP_FIND, 0, 64'sd0, 0, 1);
		d.result = make_result(0, 0, 1, ST_OK, 0, 1);
		dir_rows.push_back(d);
		d.typed = 0;
		// These inserts raise the width from class to class, though not every insert widens it.
		foreach (vals[i]) begin
			d.item = make_item(OP_INSERT, i % 2 ? 0 : i, vals[i], 0, 0);
			dir_rows.push_back(d);
		end
		d.item = make_item(OP_GET, 10, 64'sd0, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_SET, 3, INT64_MIN, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_FIND, 2, INT64_MIN, 0, 1);
		dir_rows.push_back(d);
		d.item = make_item(OP_FIND, 4, 64'sd7, 4, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_FIND, 5, 64'sd7, 3, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_FIND, 0, 64'sd7, 1500, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_DELETE, 0, 64'sd0, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_DELETE, 2047, 64'sd0, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_SPARE6, 0, 64'sd0, 0, 0);
		dir_rows.push_back(d);
		d.item = make_item(OP_SPARE7, 0, 64'sd0, 0, 0);
		dir_rows.push_back(d);
		d.typed = 1;
		d.item = make_item(OP_CLEAR, 0, 64'sd0, 0, 0);
		d.result = make_result(0, 0, 0, ST_OK, 0, 0);
		dir_rows.push_back(d);
		// A wide find on an empty list after clear.
		d.item = make_item(OP_FIND, 0, INT64_MAX, 0, 1);
		dir_rows.push_back(d);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cur_width = 0;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		longest_list = 0;
		quiet = 0;
		build_directed();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

		drain();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 60 == 0) quiet = ($urandom_range(0, 2) == 0);
			send_checked(random_item());
		end
		quiet = 0;

		// Hold off until every result is back, then empty the list.
		drain();
		send_checked(make_item(OP_CLEAR, 0, 64'sd0, 0, 0));

		drain();
		if (pending_results.size() != 0) fail_count++;
		$display("Sent %0d items, checked %0d results; longest list %0d entries.",
			items_sent, results_checked, longest_list);
		$display("Covered every operation, all widths, bad index, bad ranges and finds.");
		if (fail_count == 0) begin
			$display("adaptive_width_packed_int_array_tb passed");
		end else begin
			$display("adaptive_width_packed_int_array_tb failed");
		end
		$finish;
	end

	initial begin
		int gap;
		out_item_t want;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = quiet ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result item arrived with nothing expected");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.read_value !== want.read_value) begin
					$error("read_value expected %0d got %0d", want.read_value, out_data.read_value);
					fail_count++;
				end
				if (out_data.match_index !== want.match_index) begin
					$error("match_index expected %0d got %0d", want.match_index,
						out_data.match_index);
					fail_count++;
				end
				if (out_data.match_found !== want.match_found) begin
					$error("match_found expected %0d got %0d", want.match_found,
						out_data.match_found);
					fail_count++;
				end
				if (out_data.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, out_data.status);
					fail_count++;
				end
				if (out_data.entry_width !== want.entry_width) begin
					$error("entry_width expected %0d got %0d", want.entry_width,
						out_data.entry_width);
					fail_count++;
				end
				if (out_data.entry_count !== want.entry_count) begin
					$error("entry_count expected %0d got %0d", want.entry_count,
						out_data.entry_count);
					fail_count++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: any long stretch with no item moving on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("adaptive_width_packed_int_array_tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
